[sv/websocket_frame_decoder_top_macros.svh]
// assertion macros shared by the frame decoder rtl
`ifndef WEBSOCKET_FRAME_DECODER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DECODER_TOP_MACROS_SVH

// condition checked at every clock edge outside reset
`define WSFD_ASSERT_NOW(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);

`endif

[sv/wsfd_pkg.sv]
// types and constants of the websocket frame decoder
package wsfd_pkg;

   typedef enum logic [3:0] {
      PH_HDR0    = 4'd0,
      PH_HDR1    = 4'd1,
      PH_LENHI   = 4'd2,
      PH_LENLO   = 4'd3,
      PH_KEY0    = 4'd4,
      PH_KEY1    = 4'd5,
      PH_KEY2    = 4'd6,
      PH_KEY3    = 4'd7,
      PH_PAYLOAD = 4'd8,
      PH_ERROR   = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      OPC_CONT    = 3'd0,
      OPC_TEXT    = 3'd1,
      OPC_BINARY  = 3'd2,
      OPC_CLOSE   = 3'd3,
      OPC_PING    = 3'd4,
      OPC_PONG    = 3'd5,
      OPC_UNKNOWN = 3'd6
   } opcode_type;

   localparam logic [3:0] NIB_CONT   = 4'h0;
   localparam logic [3:0] NIB_TEXT   = 4'h1;
   localparam logic [3:0] NIB_BINARY = 4'h2;
   localparam logic [3:0] NIB_CLOSE  = 4'h8;
   localparam logic [3:0] NIB_PING   = 4'h9;
   localparam logic [3:0] NIB_PONG   = 4'hA;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        data_valid;
      logic [2:0]  frame_opcode;
      logic        final_fragment;
      logic        frame_end;
      logic [15:0] payload_length;
      logic        error_flag;
   } result_type;

   function automatic opcode_type map_opcode(input logic [3:0] nib);
      opcode_type opc;
      case (nib)
         NIB_CONT:   opc = OPC_CONT;
         NIB_TEXT:   opc = OPC_TEXT;
         NIB_BINARY: opc = OPC_BINARY;
         NIB_CLOSE:  opc = OPC_CLOSE;
         NIB_PING:   opc = OPC_PING;
         NIB_PONG:   opc = OPC_PONG;
         default:    opc = OPC_UNKNOWN;
      endcase
      return opc;
   endfunction

endpackage

[sv/wsfd_if.sv]
// valid/ready channel interfaces for received bytes and decoded results
interface wsfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        data_valid;
   logic [2:0]  frame_opcode;
   logic        final_fragment;
   logic        frame_end;
   logic [15:0] payload_length;
   logic        error_flag;

   modport source (output valid, output data_byte, output data_valid, output frame_opcode,
                   output final_fragment, output frame_end, output payload_length,
                   output error_flag, input ready);
   modport sink   (input valid, input data_byte, input data_valid, input frame_opcode,
                   input final_fragment, input frame_end, input payload_length,
                   input error_flag, output ready);
endinterface

[sv/websocket_frame_decoder_top.sv]
// websocket frame decoder: byte-serial header parse and payload unmasking
//
//   channel   direction  payload
//   req_if    in         rx_byte: next byte of the frame stream
//   rsp_if    out        data_byte, data_valid, frame_opcode, final_fragment,
//                        frame_end, payload_length, error_flag
//
// one byte per cycle unless rsp_if stalls; a byte goes input register -> parse ->
// result register, and rsp_if is driven straight from the result register
// every payload byte gives one result; header bytes give none, except the byte
// that completes an empty frame's header (end marker) and a 64-bit length code (error)
// req_if.ready follows rsp_if.ready through the input register's advance term
// synchronous reset returns to the first header byte and clears a 64-bit length error
`include "websocket_frame_decoder_top_macros.svh"

module websocket_frame_decoder_top (
   input logic        clock,
   input logic        reset,
   wsfd_req_if.sink   req_if,
   wsfd_rsp_if.source rsp_if
);
   import wsfd_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        advance;

   phase_type   phase_ff, phase_in;
   logic        fin_ff, fin_in;
   opcode_type  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] done_ff, done_in;
   logic [7:0]  key_ff [4];
   logic [7:0]  key_in [4];

   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   logic        produce;
   result_type  res;

   logic [6:0]  len_code;
   logic [15:0] done_inc;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   assign len_code = in_byte_ff[6:0];
   assign done_inc = done_ff + 16'd1;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_if.valid && req_if.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         case (phase_ff)
            PH_HDR1: begin
               if (len_code == LEN_EXT64) begin
                  phase_in = PH_ERROR;
               end else if (len_code == LEN_EXT16) begin
                  phase_in = PH_LENHI;
               end else if (in_byte_ff[7]) begin
                  phase_in = PH_KEY0;
               end else if (len_code == 7'd0) begin
                  phase_in = PH_HDR0;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_LENHI: phase_in = PH_LENLO;
            PH_LENLO: begin
               if (masked_ff) begin
                  phase_in = PH_KEY0;
               end else if ({length_ff[15:8], in_byte_ff} == 16'd0) begin
                  phase_in = PH_HDR0;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_KEY0: phase_in = PH_KEY1;
            PH_KEY1: phase_in = PH_KEY2;
            PH_KEY2: phase_in = PH_KEY3;
            PH_KEY3: phase_in = (length_ff == 16'd0) ? PH_HDR0 : PH_PAYLOAD;
            PH_PAYLOAD: phase_in = (done_inc == length_ff) ? PH_HDR0 : PH_PAYLOAD;
            PH_ERROR: phase_in = PH_ERROR;
            default: phase_in = PH_HDR1;
         endcase
      end
   end

   // frame fields and result
   always_comb begin
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      length_in = length_ff;
      done_in   = done_ff;
      key_in    = key_ff;
      produce   = 1'b0;
      res.data_byte      = 8'd0;
      res.data_valid     = 1'b0;
      res.frame_opcode   = opcode_ff;
      res.final_fragment = fin_ff;
      res.frame_end      = 1'b1;
      res.payload_length = 16'd0;
      res.error_flag     = 1'b0;
      if (advance) begin
         case (phase_ff)
            PH_HDR1: begin
               masked_in = in_byte_ff[7];
               done_in   = 16'd0;
               if (len_code == LEN_EXT64) begin
                  opcode_in          = OPC_UNKNOWN;
                  length_in          = 16'd0;
                  produce            = 1'b1;
                  res.frame_opcode   = OPC_UNKNOWN;
                  res.frame_end      = 1'b0;
                  res.error_flag     = 1'b1;
               end else if (len_code != LEN_EXT16) begin
                  length_in = {9'd0, len_code};
                  produce   = !in_byte_ff[7] && (len_code == 7'd0);
               end
            end
            PH_LENHI: length_in = {in_byte_ff, 8'd0};
            PH_LENLO: begin
               length_in = {length_ff[15:8], in_byte_ff};
               done_in   = 16'd0;
               produce   = !masked_ff && ({length_ff[15:8], in_byte_ff} == 16'd0);
            end
            PH_KEY0: key_in[0] = in_byte_ff;
            PH_KEY1: key_in[1] = in_byte_ff;
            PH_KEY2: key_in[2] = in_byte_ff;
            PH_KEY3: begin
               key_in[3] = in_byte_ff;
               done_in   = 16'd0;
               produce   = (length_ff == 16'd0);
            end
            PH_PAYLOAD: begin
               done_in            = done_inc;
               produce            = 1'b1;
               res.data_byte      = masked_ff ? (in_byte_ff ^ key_ff[done_ff[1:0]]) : in_byte_ff;
               res.data_valid     = 1'b1;
               res.frame_end      = (done_inc == length_ff);
               res.payload_length = length_ff;
            end
            PH_ERROR: produce = 1'b0;
            default: begin
               fin_in    = in_byte_ff[7];
               opcode_in = map_opcode(in_byte_ff[3:0]);
            end
         endcase
      end
   end

   // result register
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      if (advance && produce) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_HDR0;
         fin_ff       <= 1'b0;
         opcode_ff    <= OPC_CONT;
         masked_ff    <= 1'b0;
         length_ff    <= 16'd0;
         done_ff      <= 16'd0;
         key_ff       <= '{default: 8'd0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         masked_ff    <= masked_in;
         length_ff    <= length_in;
         done_ff      <= done_in;
         key_ff       <= key_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.data_byte      = out_ff.data_byte;
   assign rsp_if.data_valid     = out_ff.data_valid;
   assign rsp_if.frame_opcode   = out_ff.frame_opcode;
   assign rsp_if.final_fragment = out_ff.final_fragment;
   assign rsp_if.frame_end      = out_ff.frame_end;
   assign rsp_if.payload_length = out_ff.payload_length;
   assign rsp_if.error_flag     = out_ff.error_flag;

   `WSFD_ASSERT_NOW(a_error_sticky_phase, (out_valid_ff && out_ff.error_flag) |-> (phase_ff == PH_ERROR), "error result without error phase")
   `WSFD_ASSERT_NEXT(a_error_holds, (phase_ff == PH_ERROR), (phase_ff == PH_ERROR), "error phase left without reset")
   `WSFD_ASSERT_NOW(a_payload_count, (phase_ff == PH_PAYLOAD) |-> (done_ff < length_ff), "payload count past frame length")
   `WSFD_ASSERT_NOW(a_result_source, $rose(out_valid_ff) |-> $past(advance), "result appeared without a parsed byte")

endmodule

[test/websocket_frame_decoder_top_tb.sv]
// testbench for the websocket frame decoder: random framed byte streams checked against a predictor
`timescale 1ns / 1ps

module websocket_frame_decoder_top_tb;
   import wsfd_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wsfd_req_if req_if ();
   wsfd_rsp_if rsp_if ();

   websocket_frame_decoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic       req_valid = 1'b0;
   logic [7:0] req_byte  = 8'h00;
   logic       rsp_ready = 1'b0;
   logic       rsp_hold  = 1'b0;

   assign req_if.valid   = req_valid;
   assign req_if.rx_byte = req_byte;
   assign rsp_if.ready   = rsp_ready;

   logic [7:0] stream_bytes[$];
   result_type frame_results_due[$];
   int         send_idle_pct = 0;
   int         rsp_idle_pct  = 0;
   int         fail_count    = 0;
   int         cycle_count   = 0;
   bit         hold_start    = 1'b0;

   // parser state mirrored from the block
   phase_type   ph         = PH_HDR0;
   logic        dec_fin    = 1'b0;
   opcode_type  dec_opcode = OPC_CONT;
   logic        dec_masked = 1'b0;
   logic [15:0] dec_length = 16'd0;
   logic [15:0] dec_count  = 16'd0;
   logic [7:0]  dec_key[4] = '{8'd0, 8'd0, 8'd0, 8'd0};

   always #10 clock = ~clock;

   // header finished: empty frame gives an end marker, else payload follows
   function automatic bit finish_header(output result_type r);
      r = '0;
      dec_count = 16'd0;
      if (dec_length == 16'd0) begin
         ph = PH_HDR0;
         r.frame_opcode = dec_opcode;
         r.final_fragment = dec_fin;
         r.frame_end = 1'b1;
         return 1'b1;
      end
      ph = PH_PAYLOAD;
      return 1'b0;
   endfunction

   function automatic bit length_known(output result_type r);
      r = '0;
      if (dec_masked) begin
         ph = PH_KEY0;
         return 1'b0;
      end
      return finish_header(r);
   endfunction

   function automatic bit parse_frame_byte(input logic [7:0] b, output result_type r);
      bit         got;
      logic [7:0] d;
      got = 1'b0;
      r = '0;
      case (ph)
         PH_HDR1: begin
            dec_masked = b[7];
            if (b[6:0] == LEN_EXT64) begin
               ph = PH_ERROR;
               dec_opcode = OPC_UNKNOWN;
               dec_length = 16'd0;
               r.frame_opcode = OPC_UNKNOWN;
               r.final_fragment = dec_fin;
               r.error_flag = 1'b1;
               got = 1'b1;
            end else if (b[6:0] == LEN_EXT16) begin
               ph = PH_LENHI;
            end else begin
               dec_length = {9'd0, b[6:0]};
               got = length_known(r);
            end
         end
         PH_LENHI: begin
            dec_length = {b, 8'd0};
            ph = PH_LENLO;
         end
         PH_LENLO: begin
            dec_length = dec_length | {8'd0, b};
            got = length_known(r);
         end
         PH_KEY0, PH_KEY1, PH_KEY2, PH_KEY3: begin
            dec_key[ph[1:0]] = b;
            if (ph == PH_KEY3)
               got = finish_header(r);
            else
               ph = phase_type'(ph + 4'd1);
         end
         PH_PAYLOAD: begin
            d = dec_masked ? (b ^ dec_key[dec_count[1:0]]) : b;
            dec_count = dec_count + 16'd1;
            r.data_byte = d;
            r.data_valid = 1'b1;
            r.frame_opcode = dec_opcode;
            r.final_fragment = dec_fin;
            r.frame_end = (dec_count == dec_length);
            r.payload_length = dec_length;
            if (r.frame_end)
               ph = PH_HDR0;
            got = 1'b1;
         end
         PH_ERROR: begin
            got = 1'b0;
         end
         default: begin
            dec_fin = b[7];
            case (b[3:0])
               NIB_CONT:   dec_opcode = OPC_CONT;
               NIB_TEXT:   dec_opcode = OPC_TEXT;
               NIB_BINARY: dec_opcode = OPC_BINARY;
               NIB_CLOSE:  dec_opcode = OPC_CLOSE;
               NIB_PING:   dec_opcode = OPC_PING;
               NIB_PONG:   dec_opcode = OPC_PONG;
               default:    dec_opcode = OPC_UNKNOWN;
            endcase
            ph = PH_HDR1;
         end
      endcase
      return got;
   endfunction

   task automatic add_frame(input logic [7:0] first, input bit masked, input bit ext,
                            input logic [15:0] len);
      int i;
      stream_bytes.push_back(first);
      if (ext) begin
         stream_bytes.push_back({masked, LEN_EXT16});
         stream_bytes.push_back(len[15:8]);
         stream_bytes.push_back(len[7:0]);
      end else begin
         stream_bytes.push_back({masked, len[6:0]});
      end
      if (masked)
         for (i = 0; i < 4; i++)
            stream_bytes.push_back(8'($urandom));
      for (i = 0; i < int'(len); i++)
         stream_bytes.push_back(8'($urandom));
   endtask

   task automatic add_random_frames(input int target);
      logic [3:0]  nibs[6];
      logic [7:0]  first;
      logic [15:0] len;
      bit          ext;
      int          sel;
      int          start;
      nibs = '{NIB_CONT, NIB_TEXT, NIB_BINARY, NIB_CLOSE, NIB_PING, NIB_PONG};
      start = stream_bytes.size();
      while (stream_bytes.size() - start < target) begin
         first = 8'($urandom);
         // mostly defined opcodes, the rest any nibble
         if ($urandom_range(99) < 60)
            first[3:0] = nibs[3'($urandom_range(5))];
         sel = $urandom_range(99);
         ext = 1'b0;
         if (sel < 15) begin
            len = 16'd0;
         end else if (sel < 70) begin
            len = 16'($urandom_range(1, 12));
         end else if (sel < 85) begin
            len = 16'($urandom_range(13, 125));
         end else if (sel < 97) begin
            // extended length that would also fit the short code
            len = 16'($urandom_range(0, 40));
            ext = 1'b1;
         end else begin
            len = 16'($urandom_range(126, 300));
            ext = 1'b1;
         end
         add_frame(first, 1'($urandom_range(1)), ext, len);
      end
   endtask

   task automatic drain;
      while (stream_bytes.size() != 0 || req_valid || frame_results_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // driver: offer queued bytes, predict each accepted transaction
   always @(posedge clock) begin : driver
      result_type res;
      if (reset) begin
         req_valid <= 1'b0;
         req_byte <= 8'h00;
      end else begin
         if (req_valid && req_if.ready) begin
            if (parse_frame_byte(req_byte, res))
               frame_results_due.push_back(res);
         end
         if (!req_valid || req_if.ready) begin
            if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_byte <= stream_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
               req_byte <= 8'($urandom);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin : monitor
      result_type want;
      if (!reset && rsp_if.valid && rsp_ready) begin
         if (frame_results_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual data %0h valid %0b",
                     $time, rsp_if.data_byte, rsp_if.data_valid);
            $display("   opcode %0d fin %0b end %0b length %0h error %0b",
                     rsp_if.frame_opcode, rsp_if.final_fragment, rsp_if.frame_end,
                     rsp_if.payload_length, rsp_if.error_flag);
            fail_count++;
         end else begin
            want = frame_results_due.pop_front();
            check_field("data_byte", want.data_byte, rsp_if.data_byte);
            check_field("data_valid", want.data_valid, rsp_if.data_valid);
            check_field("frame_opcode", want.frame_opcode, rsp_if.frame_opcode);
            check_field("final_fragment", want.final_fragment, rsp_if.final_fragment);
            check_field("frame_end", want.frame_end, rsp_if.frame_end);
            check_field("payload_length", want.payload_length, rsp_if.payload_length);
            check_field("error_flag", want.error_flag, rsp_if.error_flag);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("websocket_frame_decoder_top test failed");
         $finish;
      end
   end

   // long receiver stall so the pipeline fills and backpressures the input
   initial begin
      wait (hold_start);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      int i;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 36;
      rsp_idle_pct = 46;
      // empty unmasked continuation with fin
      stream_bytes.push_back(8'h80);
      stream_bytes.push_back(8'h00);
      // empty masked ping, end marker on the last key byte
      stream_bytes.push_back(8'h89);
      stream_bytes.push_back(8'h80);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'hA5);
      stream_bytes.push_back(8'h5A);
      // reserved bits set, close, one unmasked byte
      stream_bytes.push_back(8'h78);
      stream_bytes.push_back(8'h01);
      stream_bytes.push_back(8'hFF);
      // masked pong with a short extended length of 3
      stream_bytes.push_back(8'h8A);
      stream_bytes.push_back({1'b1, LEN_EXT16});
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'h03);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'hC3);
      stream_bytes.push_back(8'h5A);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'h3C);
      // empty binary via the extended length
      stream_bytes.push_back(8'h02);
      stream_bytes.push_back({1'b0, LEN_EXT16});
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'h00);
      add_random_frames(500);
      drain();

      send_idle_pct = 46;
      rsp_idle_pct = 36;
      add_random_frames(500);
      drain();

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      add_random_frames(450);
      hold_start = 1'b1;
      add_frame(8'h82, 1'b1, 1'b1, 16'd200);
      drain();

      // 64-bit length code, then bytes that the sticky error drops
      stream_bytes.push_back(8'hF5);
      stream_bytes.push_back({1'b1, LEN_EXT64});
      for (i = 0; i < 20; i++)
         stream_bytes.push_back(8'($urandom));
      drain();

      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("websocket_frame_decoder_top test passed");
      else
         $display("websocket_frame_decoder_top test failed");
      $finish;
   end

endmodule
